// ===== src/lfps_pkg.sv =====
package lfps_pkg;

	localparam int MAX_WIDTH      = 1024;
	localparam int SAMPLE_BITS    = 32;
	localparam int RES_BITS       = SAMPLE_BITS + 3;
	localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
	localparam int WIDTH_REG_BITS = 11;
	localparam int COUNT_REG_BITS = 16;
	localparam int ROW_BITS       = COUNT_REG_BITS + 1;
	localparam int COLS_BITS      = ADDR_BITS + 1;
	localparam int CMP_BITS       = (WIDTH_REG_BITS > COLS_BITS) ? WIDTH_REG_BITS : COLS_BITS;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int WORD_BITS      = 2 * SAMPLE_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_WIDTH = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_ROW_COUNT = CFG_INDEX_BITS'(1);

	localparam logic [WIDTH_REG_BITS-1:0] RESET_ROW_WIDTH = WIDTH_REG_BITS'(1024);
	localparam logic [COUNT_REG_BITS-1:0] RESET_ROW_COUNT = COUNT_REG_BITS'(1024);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [RES_BITS-1:0]    result_t;
	typedef logic [ADDR_BITS-1:0]          addr_t;

	typedef struct packed {
		logic  step;
		addr_t col;
		logic  first_col;
		logic  last_col;
		logic  flushing;
		logic  has_mid;
		logic  has_up;
		addr_t rd_a;
		addr_t rd_b;
		logic  rgt_ok;
	} lfps_ctl_t;

endpackage

// ===== src/laplacian_five_point_stencil.sv =====
// Five-point Laplacian over a raster-order grid of signed Q16.16 samples.
// Input channel (in_valid/in_stall, opcode, sample): a transaction moves when
// in_valid is high and in_stall low. Send row_count rows of row_width samples
// (opcode 0), then row_width flush transactions (opcode 1). A transaction whose
// opcode does not fit the current phase is taken and dropped.
// Output channel (out_valid/out_stall, laplacian, frame_end): each grid point
// yields 4*centre - up - down - left - right, with zeros outside the grid.
// Results lag one row: a point's result is loaded into the output register at
// the edge that takes the sample below it (or its flush transaction) and shows
// in the next cycle. frame_end marks the last result of a frame.
// Throughput: one transaction per cycle while no stalled result waits, set by
// the line buffer RAM (one write, two registered reads) and a one-stage result
// register. When the receiver stalls with a result waiting, in_stall rises in
// the same cycle and the result holds; input flows again once it is taken.
// Configuration (cfg_valid/cfg_ready, always ready): index 0 row_width, 1
// row_count; a write to either restarts the frame. Write only while idle.
// Reset: row_width and row_count go to 1024, the frame restarts, the output
// register empties. Line buffer contents are not cleared.
module laplacian_five_point_stencil (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lfps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lfps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  lfps_pkg::sample_t                   sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lfps_pkg::result_t                   laplacian,
	output logic                                frame_end
);
	import lfps_pkg::*;

	lfps_ctl_t ctl;
	logic      in_take;

	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && !in_stall;

	lfps_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_take   (in_take),
		.opcode    (opcode),
		.ctl       (ctl)
	);

	lfps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sample    (sample),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.laplacian (laplacian),
		.frame_end (frame_end)
	);

endmodule

// ===== src/lfps_ram.sv =====
module lfps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// ===== src/lfps_ctl.sv =====
module lfps_ctl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [lfps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lfps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                                in_take,
	input  logic                                opcode,
	output lfps_pkg::lfps_ctl_t                 ctl
);
	import lfps_pkg::*;

	logic [WIDTH_REG_BITS-1:0] row_width_q;
	logic [COUNT_REG_BITS-1:0] row_count_q;
	addr_t                     col_q;
	logic [ROW_BITS-1:0]       row_q;

	logic [CMP_BITS-1:0]       rw_ext;
	logic [CMP_BITS-1:0]       w;
	logic [COUNT_REG_BITS-1:0] h;
	logic [CMP_BITS-1:0]       col_ext;
	logic [CMP_BITS-1:0]       col_p1;
	logic [CMP_BITS-1:0]       col_p2;
	logic                      last_col;
	logic                      flushing;
	addr_t                     nxt_col;

	assign rw_ext = CMP_BITS'(row_width_q);

	always_comb begin
		if (rw_ext == '0) begin
			w = CMP_BITS'(1);
		end else if (rw_ext > CMP_BITS'(MAX_WIDTH)) begin
			w = CMP_BITS'(MAX_WIDTH);
		end else begin
			w = rw_ext;
		end
	end

	assign h        = (row_count_q == '0) ? COUNT_REG_BITS'(1) : row_count_q;
	assign col_ext  = CMP_BITS'(col_q);
	assign col_p1   = col_ext + CMP_BITS'(1);
	assign col_p2   = col_ext + CMP_BITS'(2);
	assign last_col = col_p1 >= w;
	assign flushing = row_q >= ROW_BITS'(h);
	assign nxt_col  = last_col ? '0 : col_p1[ADDR_BITS-1:0];

	assign ctl.step      = in_take && ((opcode == OP_FLUSH) == flushing);
	assign ctl.col       = col_q;
	assign ctl.first_col = col_q == '0;
	assign ctl.last_col  = last_col;
	assign ctl.flushing  = flushing;
	assign ctl.has_mid   = row_q != '0;
	assign ctl.has_up    = row_q > ROW_BITS'(1);
	assign ctl.rd_a      = nxt_col;
	assign ctl.rd_b      = nxt_col + ADDR_BITS'(1);
	assign ctl.rgt_ok    = last_col ? (w > CMP_BITS'(1)) : (col_p2 < w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= RESET_ROW_WIDTH;
			row_count_q <= RESET_ROW_COUNT;
			col_q       <= '0;
			row_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROW_WIDTH: begin
					row_width_q <= cfg_data[WIDTH_REG_BITS-1:0];
					col_q       <= '0;
					row_q       <= '0;
				end
				REG_ROW_COUNT: begin
					row_count_q <= cfg_data[COUNT_REG_BITS-1:0];
					col_q       <= '0;
					row_q       <= '0;
				end
				default: begin
				end
			endcase
		end else if (ctl.step) begin
			col_q <= nxt_col;
			if (last_col) begin
				row_q <= flushing ? '0 : row_q + ROW_BITS'(1);
			end
		end
	end

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		col_ext < w)
		else $error("column past row width");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_BITS'(h))
		else $error("row past flush row");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && last_col && flushing && !cfg_valid |=> row_q == '0 && col_q == '0)
		else $error("frame did not wrap after flush row");

endmodule

// ===== src/lfps_dp.sv =====
module lfps_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lfps_pkg::lfps_ctl_t ctl,
	input  lfps_pkg::sample_t   sample,
	input  logic                out_stall,
	output logic                in_stall,
	output logic                out_valid,
	output lfps_pkg::result_t   laplacian,
	output logic                frame_end
);
	import lfps_pkg::*;

	logic [WORD_BITS-1:0] ram_qa;
	logic [WORD_BITS-1:0] ram_qb;
	logic [WORD_BITS-1:0] wr_word;
	logic [WORD_BITS-1:0] word_a;

	logic                 byp_a_q;
	logic                 byp_b_q;
	logic                 rgt_ok_q;
	logic [WORD_BITS-1:0] byp_word_q;
	sample_t              left_q;
	logic                 out_valid_q;
	result_t              laplacian_q;
	logic                 frame_end_q;

	sample_t cen;
	sample_t up;
	sample_t below;
	sample_t left;
	sample_t rgt;
	sample_t mid_b;
	result_t res;

	assign word_a = byp_a_q ? byp_word_q : ram_qa;
	assign mid_b  = byp_b_q ? byp_word_q[SAMPLE_BITS-1:0] : ram_qb[SAMPLE_BITS-1:0];
	assign cen    = word_a[SAMPLE_BITS-1:0];
	assign up     = ctl.has_up ? sample_t'(word_a[WORD_BITS-1:SAMPLE_BITS]) : '0;
	assign below  = ctl.flushing ? '0 : sample;
	assign left   = ctl.first_col ? '0 : left_q;
	assign rgt    = rgt_ok_q ? mid_b : '0;

	assign res = (RES_BITS'(cen) <<< 2) - RES_BITS'(up) - RES_BITS'(below)
		- RES_BITS'(left) - RES_BITS'(rgt);

	assign wr_word = {cen, below};

	lfps_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk     (clk),
		.we      (ctl.step),
		.waddr   (ctl.col),
		.wdata   (wr_word),
		.re      (ctl.step),
		.raddr_a (ctl.rd_a),
		.raddr_b (ctl.rd_b),
		.rdata_a (ram_qa),
		.rdata_b (ram_qb)
	);

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			byp_word_q <= wr_word;
			left_q     <= cen;
		end
		if (ctl.step && ctl.has_mid) begin
			laplacian_q <= res;
			frame_end_q <= ctl.flushing && ctl.last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_a_q     <= 1'b0;
			byp_b_q     <= 1'b0;
			rgt_ok_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.step) begin
				byp_a_q  <= ctl.rd_a == ctl.col;
				byp_b_q  <= ctl.rd_b == ctl.col;
				rgt_ok_q <= ctl.rgt_ok;
			end
			if (ctl.step && ctl.has_mid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign laplacian = laplacian_q;
	assign frame_end = frame_end_q;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && ctl.has_mid |=> out_valid_q)
		else $error("stencil transaction lost");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.step && ctl.has_mid) && !out_valid_q |=> !out_valid_q)
		else $error("result appeared without a stencil step");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(laplacian_q)
			&& $stable(frame_end_q))
		else $error("stalled transaction changed");

endmodule
